### rtl/core/sgtr_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sgtr_pkg
// Shared types, register indexes and the 5x7 glyph ROM for the rasterizer.
// ---------------------------------------------------------------------------
package sgtr_pkg;

	localparam int GLYPH_ROWS  = 7;
	localparam int GLYPH_COLS  = 5;
	localparam int GLYPH_BITS  = GLYPH_ROWS * GLYPH_COLS;
	localparam int COL_W       = $clog2(GLYPH_COLS);
	localparam int COORD_W     = 13;
	localparam int NUM_GLYPHS  = 38;
	localparam int GIDX_W      = $clog2(NUM_GLYPHS);
	localparam int BLANK_INDEX = 36;
	localparam int COLON_INDEX = 37;

	localparam logic REG_PIXEL_SCALE = 1'b0;
	localparam logic REG_TEXT_COLOR  = 1'b1;

	localparam logic [3:0]  PIXEL_SCALE_RESET = 4'd1;
	localparam logic [31:0] TEXT_COLOR_RESET  = 32'hFFFF_FFFF;

	typedef struct packed {
		logic [7:0]  char_code;
		logic        new_string;
		logic [11:0] start_x;
		logic [11:0] start_y;
	} in_t;

	typedef struct packed {
		logic [12:0] rect_x;
		logic [12:0] rect_y;
		logic [3:0]  rect_size;
		logic [31:0] rect_color;
		logic        last_square;
	} out_t;

	typedef struct packed {
		logic load;
		logic step;
	} cmd_t;

	typedef struct packed {
		logic in_blank;
		logic cell_set;
		logic last_cell;
		logic out_free;
	} sts_t;

	// Row 0 sits in the top five bits, each row MSB first.
	localparam logic [GLYPH_BITS-1:0] GLYPH_ROM [NUM_GLYPHS] = '{
		{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E},
		{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
		{5'h0E,5'h11,5'h01,5'h06,5'h08,5'h10,5'h1F},
		{5'h0E,5'h11,5'h01,5'h06,5'h01,5'h11,5'h0E},
		{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02},
		{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
		{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E},
		{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
		{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E},
		{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
		{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E},
		{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
		{5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C},
		{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
		{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10},
		{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
		{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
		{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
		{5'h0F,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C},
		{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
		{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F},
		{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
		{5'h11,5'h19,5'h15,5'h13,5'h11,5'h11,5'h11},
		{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10},
		{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
		{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11},
		{5'h0E,5'h11,5'h10,5'h0E,5'h01,5'h11,5'h0E},
		{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
		{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04},
		{5'h11,5'h11,5'h11,5'h15,5'h15,5'h1B,5'h11},
		{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11},
		{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
		{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F},
		{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00},
		{5'h00,5'h04,5'h04,5'h00,5'h04,5'h04,5'h00}
	};

	function automatic logic [GIDX_W-1:0] glyph_index(input logic [7:0] code);
		logic [GIDX_W-1:0] idx;
		idx = GIDX_W'(BLANK_INDEX);
		if (code >= 8'h30 && code <= 8'h39) begin
			idx = GIDX_W'(code - 8'h30);
		end else if (code >= 8'h41 && code <= 8'h5A) begin
			idx = GIDX_W'(code - 8'h41 + 8'd10);
		end else if (code >= 8'h61 && code <= 8'h7A) begin
			idx = GIDX_W'(code - 8'h61 + 8'd10);
		end else if (code == 8'h3A) begin
			idx = GIDX_W'(COLON_INDEX);
		end
		return idx;
	endfunction

endpackage
`default_nettype wire

### rtl/core/sgtr_ctrl.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sgtr_ctrl
// Controller: accepts a char, scans one cell a cycle unless a set cell stalls.
// ---------------------------------------------------------------------------
module sgtr_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sgtr_pkg::sts_t sts,
	output sgtr_pkg::cmd_t     cmd
);

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	logic state_q;
	logic state_next;

	always_comb begin
		state_next = state_q;
		cmd.load   = 1'b0;
		cmd.step   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load = 1'b1;
					if (!sts.in_blank) begin
						state_next = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				cmd.step = !sts.cell_set || sts.out_free;
				if (cmd.step && sts.last_cell) begin
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	assign in_stall = (state_q != ST_IDLE);

endmodule
`default_nettype wire

### rtl/core/sgtr_datapath.sv
`default_nettype none
// ---------------------------------------------------------------------------
// sgtr_datapath
// Configuration registers, pen cursor, glyph shift register, coordinate
// accumulators and the output register.
// ---------------------------------------------------------------------------
module sgtr_datapath (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_en,
	input  wire logic          cfg_idx,
	input  wire logic [31:0]   cfg_data,
	input  wire sgtr_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sgtr_pkg::out_t     out_data,
	input  wire sgtr_pkg::cmd_t cmd,
	output sgtr_pkg::sts_t     sts
);

	localparam int CW = sgtr_pkg::COORD_W;
	localparam int GB = sgtr_pkg::GLYPH_BITS;

	logic [3:0]              scale_q;
	logic [31:0]             color_q;
	logic [CW-1:0]           cursor_q;
	logic [GB-1:0]           glyph_q;
	logic [sgtr_pkg::COL_W-1:0] col_q;
	logic [CW-1:0]           x_row_q;
	logic [CW-1:0]           x_q;
	logic [CW-1:0]           y_q;
	logic                    out_valid_q;
	sgtr_pkg::out_t          out_q;

	logic [GB-1:0]           in_glyph;
	logic [CW-1:0]           base_x;
	logic [CW-1:0]           six_scale;
	logic [CW-1:0]           scale_ext;
	logic                    emit;

	assign in_glyph  = sgtr_pkg::GLYPH_ROM[sgtr_pkg::glyph_index(in_data.char_code)];
	assign base_x    = in_data.new_string ? {1'b0, in_data.start_x} : cursor_q;
	assign scale_ext = CW'(scale_q);
	assign six_scale = CW'({scale_q, 2'b00}) + CW'({scale_q, 1'b0});
	assign emit      = cmd.step && glyph_q[GB-1];

	assign sts.in_blank  = (in_glyph == '0);
	assign sts.cell_set  = glyph_q[GB-1];
	assign sts.last_cell = (glyph_q[GB-2:0] == '0);
	assign sts.out_free  = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= sgtr_pkg::PIXEL_SCALE_RESET;
			color_q <= sgtr_pkg::TEXT_COLOR_RESET;
		end else if (cfg_en) begin
			case (cfg_idx)
				sgtr_pkg::REG_PIXEL_SCALE: scale_q <= cfg_data[3:0];
				sgtr_pkg::REG_TEXT_COLOR:  color_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
			glyph_q  <= '0;
			col_q    <= '0;
		end else if (cmd.load) begin
			cursor_q <= base_x + six_scale;
			glyph_q  <= in_glyph;
			col_q    <= '0;
		end else if (cmd.step) begin
			glyph_q <= {glyph_q[GB-2:0], 1'b0};
			if (col_q == sgtr_pkg::COL_W'(sgtr_pkg::GLYPH_COLS - 1)) begin
				col_q <= '0;
			end else begin
				col_q <= col_q + sgtr_pkg::COL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_row_q <= base_x;
			x_q     <= base_x;
			y_q     <= {1'b0, in_data.start_y};
		end else if (cmd.step) begin
			if (col_q == sgtr_pkg::COL_W'(sgtr_pkg::GLYPH_COLS - 1)) begin
				x_q <= x_row_q;
				y_q <= y_q + scale_ext;
			end else begin
				x_q <= x_q + scale_ext;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_q.rect_x      <= x_q;
			out_q.rect_y      <= y_q;
			out_q.rect_size   <= scale_q;
			out_q.rect_color  <= color_q;
			out_q.last_square <= (glyph_q[GB-2:0] == '0);
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule
`default_nettype wire

### rtl/core/scaled_glyph_text_rasterizer.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scaled_glyph_text_rasterizer
// A character is loaded into the glyph shift register; each set cell is then registered into
// the output register as the scan reaches it. Throughput: one glyph cell per cycle, ending at
// the last set cell; no new character is taken until the scan ends. A blank glyph needs no scan.
// Output stalls hold the scan at a set cell while a square waits in the output register.
// Reset clears the pen cursor to 0, scale to 1 and color to all ones.
// ---------------------------------------------------------------------------
module scaled_glyph_text_rasterizer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_en,
	input  wire logic          cfg_idx,
	input  wire logic [31:0]   cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire sgtr_pkg::in_t in_data,
	output logic               out_valid,
	input  wire logic          out_stall,
	output sgtr_pkg::out_t     out_data
);

	sgtr_pkg::cmd_t cmd;
	sgtr_pkg::sts_t sts;

	sgtr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sgtr_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

### tb/glyph_square_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// glyph_square_checker
// Watches the register port and both channels of the text rasterizer. Every
// accepted character is expanded into the squares its 5x7 glyph must produce,
// using a shadow pen cursor, scale and color. Each output beat is compared
// field by field with the oldest square still owed.
// ---------------------------------------------------------------------------
module glyph_square_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_en,
	input  wire logic        cfg_idx,
	input  wire logic [31:0] cfg_data,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire sgtr_pkg::in_t  in_data,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire sgtr_pkg::out_t out_data,
	output int               fail_count,
	output int               squares_pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FONT_SLOTS = 38;
	localparam int BLANK_SLOT = 36;
	localparam int COLON_SLOT = 37;

	localparam logic [4:0] FONT_ROWS [FONT_SLOTS][7] = '{
		'{5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E},
		'{5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0E, 5'h11, 5'h01, 5'h06, 5'h08, 5'h10, 5'h1F},
		'{5'h0E, 5'h11, 5'h01, 5'h06, 5'h01, 5'h11, 5'h0E},
		'{5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02},
		'{5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E},
		'{5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08},
		'{5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E},
		'{5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C},
		'{5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E},
		'{5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E},
		'{5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F},
		'{5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F},
		'{5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E},
		'{5'h0F, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C},
		'{5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11},
		'{5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F},
		'{5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11},
		'{5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10},
		'{5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D},
		'{5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11},
		'{5'h0E, 5'h11, 5'h10, 5'h0E, 5'h01, 5'h11, 5'h0E},
		'{5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E},
		'{5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04},
		'{5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11},
		'{5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04},
		'{5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F},
		'{5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00},
		'{5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00}
	};

	logic [3:0]      dot_size;
	logic [31:0]     ink;
	logic [12:0]     pen_x;
	sgtr_pkg::out_t  squares_due [$];
	int              mismatches;
	int              beats_seen;

	function automatic int font_slot(input logic [7:0] code);
		if (code >= 8'h30 && code <= 8'h39) return int'(code) - 'h30;
		if (code >= 8'h41 && code <= 8'h5A) return int'(code) - 'h41 + 10;
		if (code >= 8'h61 && code <= 8'h7A) return int'(code) - 'h61 + 10;
		if (code == 8'h3A) return COLON_SLOT;
		return BLANK_SLOT;
	endfunction

	function automatic void queue_squares(input sgtr_pkg::in_t ch);
		sgtr_pkg::out_t sq;
		sgtr_pkg::out_t held;
		bit   have_held;
		int   slot;
		slot = font_slot(ch.char_code);
		have_held = 1'b0;
		held = '0;
		if (ch.new_string) pen_x = 13'(ch.start_x);
		for (int row = 0; row < 7; row++) begin
			for (int col = 0; col < 5; col++) begin
				if (FONT_ROWS[slot][row][4 - col]) begin
					sq.rect_x      = pen_x + 13'(col * int'(dot_size));
					sq.rect_y      = 13'(ch.start_y) + 13'(row * int'(dot_size));
					sq.rect_size   = dot_size;
					sq.rect_color  = ink;
					sq.last_square = 1'b0;
					if (have_held) squares_due.push_back(held);
					held = sq;
					have_held = 1'b1;
				end
			end
		end
		if (have_held) begin
			held.last_square = 1'b1;
			squares_due.push_back(held);
		end
		pen_x = pen_x + 13'(6 * int'(dot_size));
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sgtr_pkg::out_t want;
		if (!arst_n) begin
			dot_size = sgtr_pkg::PIXEL_SCALE_RESET;
			ink = sgtr_pkg::TEXT_COLOR_RESET;
			pen_x = '0;
			squares_due.delete();
			mismatches = 0;
			beats_seen = 0;
		end else begin
			if (in_valid && !in_stall) queue_squares(in_data);
			if (cfg_en) begin
				if (cfg_idx == sgtr_pkg::REG_PIXEL_SCALE) begin
					dot_size = cfg_data[3:0];
				end else begin
					ink = cfg_data;
				end
			end
			if (out_valid && !out_stall) begin
				beats_seen++;
				if (squares_due.size() == 0) begin
					if (mismatches < 10) begin
						$display("beat %0d: square x=%0d y=%0d arrived with none owed",
							beats_seen, out_data.rect_x, out_data.rect_y);
					end
					mismatches++;
				end else begin
					want = squares_due.pop_front();
					if (want.rect_x !== out_data.rect_x || want.rect_y !== out_data.rect_y ||
						want.rect_size !== out_data.rect_size ||
						want.rect_color !== out_data.rect_color ||
						want.last_square !== out_data.last_square) begin
						if (mismatches < 10) begin
							$display("beat %0d: expected x=%0d y=%0d size=%0d color=%08h last=%b",
								beats_seen, want.rect_x, want.rect_y, want.rect_size,
								want.rect_color, want.last_square);
							$display("beat %0d: actual   x=%0d y=%0d size=%0d color=%08h last=%b",
								beats_seen, out_data.rect_x, out_data.rect_y,
								out_data.rect_size, out_data.rect_color, out_data.last_square);
						end
						mismatches++;
					end
				end
			end
		end
		fail_count <= mismatches;
		squares_pending <= squares_due.size();
	end

endmodule
`default_nettype wire

### tb/scaled_glyph_text_rasterizer_tb.sv
`default_nettype none
// ---------------------------------------------------------------------------
// scaled_glyph_text_rasterizer_tb
// Drives character beats into the rasterizer: a directed pass over glyph
// boundaries and coordinate extremes, then random strings under a series of
// scale and color settings, including scale zero and the widest scale with a
// cursor that wraps. The sender idles in bursts and the receiver stalls in
// changing patterns. A separate checker predicts and compares every square.
// ---------------------------------------------------------------------------
module scaled_glyph_text_rasterizer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SETTLE_CYCLES = 40;
	localparam int STYLE_PHASES  = 10;
	localparam int PHASE_CHARS   = 14;
	localparam int PROBE_COUNT   = 20;

	localparam logic [7:0] PROBE_CODES [PROBE_COUNT] = '{
		8'h30, 8'h39, 8'h41, 8'h5A, 8'h61, 8'h7A, 8'h3A, 8'h00, 8'hFF, 8'h2F,
		8'h40, 8'h5B, 8'h60, 8'h7B, 8'h38, 8'h4D, 8'h57, 8'h80, 8'h42, 8'h7F
	};

	logic           clk       = 1'b0;
	logic           arst_n    = 1'b0;
	logic           cfg_en    = 1'b0;
	logic           cfg_idx   = sgtr_pkg::REG_PIXEL_SCALE;
	logic [31:0]    cfg_data  = '0;
	logic           in_valid  = 1'b0;
	logic           in_stall;
	sgtr_pkg::in_t  in_data   = '0;
	logic           out_valid;
	logic           out_stall = 1'b0;
	sgtr_pkg::out_t out_data;
	int             fail_count;
	int             squares_pending;

	int burst_left = 0;
	bit steady     = 1'b0;
	int char_total = 0;
	int stall_mode = 0;
	int mode_left  = 0;
	int run_left   = 0;

	always #1 clk = ~clk;

	scaled_glyph_text_rasterizer i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_en    (cfg_en),
		.cfg_idx   (cfg_idx),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	glyph_square_checker i_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_en          (cfg_en),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.in_data         (in_data),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.out_data        (out_data),
		.fail_count      (fail_count),
		.squares_pending (squares_pending)
	);

	always @(posedge clk) begin
		if (mode_left == 0) begin
			mode_left <= $urandom_range(300, 40);
			stall_mode <= $urandom_range(3, 0);
		end else begin
			mode_left <= mode_left - 1;
		end
		case (stall_mode)
			0: begin
				out_stall <= 1'b0;
			end
			1: begin
				out_stall <= 1'($urandom_range(1, 0));
			end
			2: begin
				out_stall <= ~out_stall;
			end
			default: begin
				if (run_left == 0) begin
					out_stall <= ~out_stall;
					run_left <= out_stall ? $urandom_range(4, 1) : $urandom_range(16, 1);
				end else begin
					run_left <= run_left - 1;
				end
			end
		endcase
	end

	function automatic logic [7:0] pick_code();
		int r;
		r = $urandom_range(99, 0);
		if (r < 25) return 8'h30 + 8'($urandom_range(9, 0));
		if (r < 55) return 8'h41 + 8'($urandom_range(25, 0));
		if (r < 75) return 8'h61 + 8'($urandom_range(25, 0));
		if (r < 80) return 8'h3A;
		return 8'($urandom_range(255, 0));
	endfunction

	task automatic send_char(input sgtr_pkg::in_t ch);
		if (!steady && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
			burst_left = $urandom_range(12, 1);
		end
		in_data <= ch;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		if (burst_left > 0) burst_left--;
		char_total++;
	endtask

	task automatic drain_and_settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (squares_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_style(input logic [3:0] scale, input logic [31:0] color);
		cfg_en <= 1'b1;
		cfg_idx <= sgtr_pkg::REG_PIXEL_SCALE;
		cfg_data <= {28'($urandom()), scale};
		@(posedge clk);
		cfg_idx <= sgtr_pkg::REG_TEXT_COLOR;
		cfg_data <= color;
		@(posedge clk);
		cfg_en <= 1'b0;
	endtask

	task automatic send_string(input int min_len, input int max_len, input bit far_right);
		sgtr_pkg::in_t ch;
		int          len;
		int          r;
		bit          restart;
		logic [11:0] sx;
		logic [11:0] sy;
		len = $urandom_range(max_len, min_len);
		restart = far_right || ($urandom_range(4, 0) != 0);
		r = $urandom_range(7, 0);
		if (far_right || r < 2) begin
			sx = 12'hFFF - 12'($urandom_range(95, 0));
		end else if (r == 2) begin
			sx = '0;
		end else begin
			sx = 12'($urandom());
		end
		sy = ($urandom_range(5, 0) == 0) ? 12'hFFF : 12'($urandom());
		for (int i = 0; i < len; i++) begin
			ch.char_code = pick_code();
			ch.new_string = (i == 0) ? restart : ($urandom_range(29, 0) == 0);
			ch.start_x = (i == 0) ? sx : 12'($urandom());
			ch.start_y = ($urandom_range(19, 0) == 0) ? 12'($urandom()) : sy;
			send_char(ch);
		end
	endtask

	initial begin
		sgtr_pkg::in_t ch;
		logic [3:0]  scale_sel;
		logic [31:0] color_sel;
		bit          long_run;
		int          target;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < PROBE_COUNT; i++) begin
			ch.char_code = PROBE_CODES[i];
			ch.new_string = (i % 5 == 3);
			ch.start_x = (i % 2 == 1) ? 12'hFFF : 12'h000;
			ch.start_y = (i % 3 == 0) ? 12'hFFF : ((i % 3 == 1) ? 12'h000 : 12'h5A5);
			send_char(ch);
		end

		for (int p = 0; p < STYLE_PHASES; p++) begin
			long_run = 1'b0;
			case (p)
				0: begin
					scale_sel = 4'd8;
					color_sel = 32'h0000_0000;
				end
				1: begin
					scale_sel = 4'd0;
					color_sel = $urandom();
				end
				2: begin
					scale_sel = 4'd15;
					color_sel = 32'hFFFF_FFFF;
					long_run = 1'b1;
				end
				3: begin
					scale_sel = 4'd1;
					color_sel = $urandom();
				end
				default: begin
					scale_sel = 4'($urandom_range(15, 0));
					color_sel = $urandom();
				end
			endcase
			drain_and_settle();
			set_style(scale_sel, color_sel);
			steady = (p % 4 == 1);
			if (long_run) begin
				send_string(50, 60, 1'b1);
			end else begin
				target = char_total + PHASE_CHARS;
				while (char_total < target) begin
					send_string(1, 12, 1'b0);
					if ($urandom_range(9, 0) == 0) drain_and_settle();
				end
			end
		end

		drain_and_settle();
		if (fail_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	initial begin
		#1_600_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
`default_nettype wire
